@@ design/ir_ac_pkg.sv @@
// Shared types, constants and helpers for the IR air-conditioner frame transmitter.
// No dependencies; used by every module of the block.
package ir_ac_pkg;

  localparam int TICK_W     = 16;  // tick counter width, 13..32
  localparam int CFG_W      = 16;  // widest configuration register
  localparam int CFG_IDX_W  = 3;
  localparam int BYTE_W     = 8;
  localparam int POS_W      = 6;
  localparam logic [POS_W-1:0] FRAME_BITS = POS_W'(48);

  localparam logic [15:0] MARK_RST       = 16'd540;
  localparam logic [15:0] ONE_SPACE_RST  = 16'd1620;
  localparam logic [15:0] ZERO_SPACE_RST = 16'd540;
  localparam logic [15:0] HDR_MARK_RST   = 16'd4400;
  localparam logic [15:0] HDR_SPACE_RST  = 16'd4400;
  localparam logic [15:0] GAP_SPACE_RST  = 16'd5220;
  localparam logic [7:0]  ADDR_RST       = 8'hB2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MARK       = 3'd0,
    REG_ONE_SPACE  = 3'd1,
    REG_ZERO_SPACE = 3'd2,
    REG_HDR_MARK   = 3'd3,
    REG_HDR_SPACE  = 3'd4,
    REG_GAP_SPACE  = 3'd5,
    REG_ADDR       = 3'd6
  } reg_idx_t;

  typedef enum logic [7:0] {
    PH_IDLE      = 8'b0000_0001,
    PH_HDR_MARK  = 8'b0000_0010,
    PH_HDR_SPACE = 8'b0000_0100,
    PH_BIT_MARK  = 8'b0000_1000,
    PH_BIT_SPACE = 8'b0001_0000,
    PH_GAP_MARK  = 8'b0010_0000,
    PH_GAP_SPACE = 8'b0100_0000,
    PH_STOP_MARK = 8'b1000_0000
  } phase_t;

  typedef struct packed {
    logic [15:0]       mark_ticks;
    logic [15:0]       one_space_ticks;
    logic [15:0]       zero_space_ticks;
    logic [15:0]       header_mark_ticks;
    logic [15:0]       header_space_ticks;
    logic [15:0]       gap_space_ticks;
    logic [BYTE_W-1:0] address_byte;
  } cfg_t;

  typedef struct packed {
    logic carrier_on;
    logic busy_res;
    logic frame_done;
    logic start_rejected;
  } res_t;

  // Segment length: zero acts as one tick, anything above the counter range saturates.
  function automatic logic [TICK_W-1:0] load_len(input logic [15:0] v);
    logic [31:0] ext;
    logic [31:0] cmax;
    ext  = 32'(v);
    cmax = 32'((64'd1 << TICK_W) - 64'd1);
    if (v == 16'd0) begin
      return TICK_W'(1);
    end else if (ext > cmax) begin
      return TICK_W'(cmax);
    end else begin
      return TICK_W'(ext);
    end
  endfunction

endpackage

@@ design/ir_ac_frame_transmitter_unit.sv @@
// IR air-conditioner frame transmitter, top level.
// A request's result is written into the output register on acceptance and appears there in the next cycle.
// Throughput: one request per cycle while in_stall is low; a held result is replaced in the cycle it is taken.
// The sequencer updates on acceptance, so the next request follows with no gap.
// Reset (rst_n low, synchronous): idle, no result held, registers at default timings.
// Depends on ir_ac_pkg, ir_ac_cfg_regs and ir_ac_seq.
module ir_ac_frame_transmitter_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_action,
  input  logic [ir_ac_pkg::BYTE_W-1:0]    in_mode_byte,
  input  logic [ir_ac_pkg::BYTE_W-1:0]    in_temp_byte,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_carrier_on,
  output logic                            out_busy_res,
  output logic                            out_frame_done,
  output logic                            out_start_rejected,
  input  logic                            cfg_we,
  input  logic [ir_ac_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ir_ac_pkg::CFG_W-1:0]     cfg_wdata
);
  import ir_ac_pkg::*;

  cfg_t cfg;
  res_t res;
  res_t res_r;
  logic out_valid_r, out_valid_nxt;
  logic req_acc;

  // hold off new requests only while a result waits and is itself stalled
  assign in_stall = out_valid_r & out_stall;
  assign req_acc  = in_valid & ~in_stall;

  ir_ac_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  ir_ac_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_acc   (req_acc),
    .action    (in_action),
    .mode_byte (in_mode_byte),
    .temp_byte (in_temp_byte),
    .cfg       (cfg),
    .res       (res)
  );

  assign out_valid_nxt = req_acc | (out_valid_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (req_acc) begin
      res_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_carrier_on     = res_r.carrier_on;
  assign out_busy_res       = res_r.busy_res;
  assign out_frame_done     = res_r.frame_done;
  assign out_start_rejected = res_r.start_rejected;

endmodule

@@ design/ir_ac_cfg_regs.sv @@
// Configuration register bank of the IR frame transmitter.
// Depends on ir_ac_pkg for the register indexes, reset values and cfg_t.
module ir_ac_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [ir_ac_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ir_ac_pkg::CFG_W-1:0]     cfg_wdata,
  output ir_ac_pkg::cfg_t                cfg
);
  import ir_ac_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_MARK:       cfg_nxt.mark_ticks         = cfg_wdata;
        REG_ONE_SPACE:  cfg_nxt.one_space_ticks    = cfg_wdata;
        REG_ZERO_SPACE: cfg_nxt.zero_space_ticks   = cfg_wdata;
        REG_HDR_MARK:   cfg_nxt.header_mark_ticks  = cfg_wdata;
        REG_HDR_SPACE:  cfg_nxt.header_space_ticks = cfg_wdata;
        REG_GAP_SPACE:  cfg_nxt.gap_space_ticks    = cfg_wdata;
        REG_ADDR:       cfg_nxt.address_byte       = cfg_wdata[BYTE_W-1:0];
        default:        cfg_nxt = cfg_r;  // drop writes beyond the bank
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mark_ticks         <= MARK_RST;
      cfg_r.one_space_ticks    <= ONE_SPACE_RST;
      cfg_r.zero_space_ticks   <= ZERO_SPACE_RST;
      cfg_r.header_mark_ticks  <= HDR_MARK_RST;
      cfg_r.header_space_ticks <= HDR_SPACE_RST;
      cfg_r.gap_space_ticks    <= GAP_SPACE_RST;
      cfg_r.address_byte       <= ADDR_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

@@ design/ir_ac_seq.sv @@
// Segment sequencer: phase, bit position, frame flag, tick counter and held bytes.
// Depends on ir_ac_pkg; produces the result of the request accepted this cycle.
module ir_ac_seq (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         req_acc,
  input  logic                         action,
  input  logic [ir_ac_pkg::BYTE_W-1:0] mode_byte,
  input  logic [ir_ac_pkg::BYTE_W-1:0] temp_byte,
  input  ir_ac_pkg::cfg_t              cfg,
  output ir_ac_pkg::res_t              res
);
  import ir_ac_pkg::*;

  phase_t              phase_r, phase_nxt;
  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic                second_r, second_nxt;
  logic [TICK_W-1:0]   ticks_r, ticks_nxt;
  logic [BYTE_W-1:0]   mode_r, mode_nxt;
  logic [BYTE_W-1:0]   temp_r, temp_nxt;

  logic [BYTE_W-1:0]   cur_byte;
  logic                cur_bit;
  logic                level;
  logic [POS_W-1:0]    pos_inc;

  // Bit to send: byte chosen by the upper position bits, MSB first.
  always_comb begin
    unique case (pos_r[5:3])
      3'd0:    cur_byte = cfg.address_byte;
      3'd1:    cur_byte = ~cfg.address_byte;
      3'd2:    cur_byte = mode_r;
      3'd3:    cur_byte = ~mode_r;
      3'd4:    cur_byte = temp_r;
      default: cur_byte = ~temp_r;
    endcase
    cur_bit = cur_byte[3'd7 - pos_r[2:0]];
  end

  assign level = (phase_r == PH_HDR_MARK) || (phase_r == PH_BIT_MARK) ||
                 (phase_r == PH_GAP_MARK) || (phase_r == PH_STOP_MARK);
  assign pos_inc = pos_r + POS_W'(1);

  always_comb begin
    phase_nxt  = phase_r;
    pos_nxt    = pos_r;
    second_nxt = second_r;
    ticks_nxt  = ticks_r;
    mode_nxt   = mode_r;
    temp_nxt   = temp_r;
    res        = '0;

    if (req_acc) begin
      if (action) begin
        res.busy_res = 1'b1;
        if (phase_r != PH_IDLE) begin
          res.start_rejected = 1'b1;
          res.carrier_on     = level;
        end else begin
          mode_nxt   = mode_byte;
          temp_nxt   = temp_byte;
          second_nxt = 1'b0;
          pos_nxt    = '0;
          phase_nxt  = PH_HDR_MARK;
          ticks_nxt  = load_len(cfg.header_mark_ticks);
        end
      end else if (phase_r != PH_IDLE) begin
        res.busy_res   = 1'b1;
        res.carrier_on = level;
        if (ticks_r > TICK_W'(1)) begin
          ticks_nxt = ticks_r - TICK_W'(1);
        end else begin
          // segment over: load the next one
          unique case (phase_r)
            PH_HDR_MARK: begin
              phase_nxt = PH_HDR_SPACE;
              ticks_nxt = load_len(cfg.header_space_ticks);
            end
            PH_HDR_SPACE: begin
              phase_nxt = PH_BIT_MARK;
              pos_nxt   = '0;
              ticks_nxt = load_len(cfg.mark_ticks);
            end
            PH_BIT_MARK: begin
              phase_nxt = PH_BIT_SPACE;
              ticks_nxt = load_len(cur_bit ? cfg.one_space_ticks : cfg.zero_space_ticks);
            end
            PH_BIT_SPACE: begin
              if (pos_inc >= FRAME_BITS) begin
                pos_nxt   = '0;
                phase_nxt = second_r ? PH_STOP_MARK : PH_GAP_MARK;
              end else begin
                pos_nxt   = pos_inc;
                phase_nxt = PH_BIT_MARK;
              end
              ticks_nxt = load_len(cfg.mark_ticks);
            end
            PH_GAP_MARK: begin
              phase_nxt = PH_GAP_SPACE;
              ticks_nxt = load_len(cfg.gap_space_ticks);
            end
            PH_GAP_SPACE: begin
              second_nxt = 1'b1;
              phase_nxt  = PH_HDR_MARK;
              ticks_nxt  = load_len(cfg.header_mark_ticks);
            end
            PH_STOP_MARK: begin
              phase_nxt      = PH_IDLE;
              second_nxt     = 1'b0;
              pos_nxt        = '0;
              ticks_nxt      = '0;
              res.frame_done = 1'b1;
            end
            default: begin
              phase_nxt = PH_IDLE;
              ticks_nxt = '0;
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      pos_r    <= '0;
      second_r <= 1'b0;
      ticks_r  <= '0;
    end else begin
      phase_r  <= phase_nxt;
      pos_r    <= pos_nxt;
      second_r <= second_nxt;
      ticks_r  <= ticks_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= '0;
      temp_r <= '0;
    end else begin
      mode_r <= mode_nxt;
      temp_r <= temp_nxt;
    end
  end

endmodule
